// ===== src/dbd_pkg.sv =====
// ----------------------------------------------------------------------------
// dbd_pkg
// shared types, constants and calendar helpers for the day count block
// ----------------------------------------------------------------------------
package dbd_pkg;

  localparam int COUNT_BITS = 15;
  localparam int YEAR_BITS  = 14;
  localparam int MONTH_BITS = 4;
  localparam int DAY_BITS   = 5;

  localparam int IN_DATA_BITS  = 48;
  localparam int OUT_DATA_BITS = 16;
  localparam int STATUS_BITS   = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_CAP  = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS:0]   COUNT_OVER = {1'b1, {COUNT_BITS{1'b0}}};

  localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_BITS-1:0]   DAY_FIRST = 5'd1;

  localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_INVALID = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_SAT     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CHECK,
    ST_WALK,
    ST_FINISH,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic check;
    logic step;
    logic finish;
  } dbd_cmd_t;

  typedef struct packed {
    logic invalid;
    logic start_ge_end;
    logic walk_end;
  } dbd_sts_t;

  // leap rule via divisibility by 4, 25 and 16; y/25 by reciprocal multiply
  function automatic logic is_leap(input logic [YEAR_BITS-1:0] y);
    logic [26:0]          prod;
    logic [9:0]           quo;
    logic [YEAR_BITS-1:0] rem;
    logic                 by4;
    logic                 by25;
    logic                 by16;
    prod = 27'(y) * 27'd5243;
    quo  = prod[26:17];
    rem  = y - ({4'b0, quo} * 14'd25);
    by4  = (y[1:0] == 2'b00);
    by16 = (y[3:0] == 4'b0000);
    by25 = (rem == '0);
    return by4 && (!by25 || by16);
  endfunction

  function automatic logic [DAY_BITS-1:0] days_in_month(input logic [MONTH_BITS-1:0] m,
                                                        input logic leap);
    logic [DAY_BITS-1:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      MONTH_FEB:                                  n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== src/dbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dbd_ctrl
// sequencer for load, check, day walk and result handoff
// ----------------------------------------------------------------------------
module dbd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dbd_pkg::dbd_sts_t sts_i,
  output dbd_pkg::dbd_cmd_t cmd_o
);

  dbd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      dbd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = dbd_pkg::ST_PREP;
        end
      end
      dbd_pkg::ST_PREP: begin
        state_d = dbd_pkg::ST_CHECK;
      end
      dbd_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.invalid || sts_i.start_ge_end) begin
          state_d = dbd_pkg::ST_FINISH;
        end else begin
          state_d = dbd_pkg::ST_WALK;
        end
      end
      dbd_pkg::ST_WALK: begin
        if (sts_i.walk_end) begin
          state_d = dbd_pkg::ST_FINISH;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      dbd_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = dbd_pkg::ST_OUT;
      end
      dbd_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = dbd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dbd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/dbd_dp.sv =====
// ----------------------------------------------------------------------------
// dbd_dp
// date registers, leap flags, one-day stepper, counter and result register
// ----------------------------------------------------------------------------
module dbd_dp (
  input  logic                                clk_i,
  input  logic [dbd_pkg::IN_DATA_BITS-1:0]    in_data_i,
  input  logic                                in_inc_i,
  input  dbd_pkg::dbd_cmd_t                   cmd_i,
  output dbd_pkg::dbd_sts_t                   sts_o,
  output logic [dbd_pkg::COUNT_BITS-1:0]      total_o,
  output logic [dbd_pkg::STATUS_BITS-1:0]     status_o
);

  logic [dbd_pkg::YEAR_BITS-1:0]  wy_q, wy_d, ey_q;
  logic [dbd_pkg::MONTH_BITS-1:0] wm_q, wm_d, em_q;
  logic [dbd_pkg::DAY_BITS-1:0]   wd_q, wd_d, ed_q;
  logic                           inc_q;
  logic                           inv_q;
  logic                           wleap_q, eleap_q;
  logic [dbd_pkg::COUNT_BITS:0]   cnt_q, cnt_d;
  logic [dbd_pkg::COUNT_BITS-1:0] total_q;
  logic [dbd_pkg::STATUS_BITS-1:0] status_q;

  logic [dbd_pkg::DAY_BITS-1:0] wlen, elen;
  logic                         same_date;

  assign wlen      = dbd_pkg::days_in_month(wm_q, wleap_q);
  assign elen      = dbd_pkg::days_in_month(em_q, eleap_q);
  assign same_date = ({wy_q, wm_q, wd_q} == {ey_q, em_q, ed_q});

  assign sts_o.invalid = (wd_q == '0) || (wd_q > wlen) || (ed_q == '0) || (ed_q > elen);
  assign sts_o.start_ge_end = ({wy_q, wm_q, wd_q} >= {ey_q, em_q, ed_q});
  assign sts_o.walk_end     = same_date || (cnt_q == dbd_pkg::COUNT_OVER);

  // next calendar day
  always_comb begin
    wy_d = wy_q;
    wm_d = wm_q;
    wd_d = wd_q + 5'd1;
    if (wd_q == wlen) begin
      wd_d = dbd_pkg::DAY_FIRST;
      if (wm_q == dbd_pkg::MONTH_DEC) begin
        wm_d = dbd_pkg::MONTH_JAN;
        wy_d = wy_q + 14'd1;
      end else begin
        wm_d = wm_q + 4'd1;
      end
    end
    cnt_d = cnt_q + (dbd_pkg::COUNT_BITS + 1)'(1);
  end

  always_ff @(posedge clk_i) begin
    wleap_q <= dbd_pkg::is_leap(wy_q);
    eleap_q <= dbd_pkg::is_leap(ey_q);
    if (cmd_i.load) begin
      wy_q  <= in_data_i[13:0];
      wm_q  <= in_data_i[17:14];
      wd_q  <= in_data_i[22:18];
      ey_q  <= in_data_i[36:23];
      em_q  <= in_data_i[40:37];
      ed_q  <= in_data_i[45:41];
      inc_q <= in_inc_i;
    end
    if (cmd_i.check) begin
      inv_q <= sts_o.invalid;
      cnt_q <= {{dbd_pkg::COUNT_BITS{1'b0}}, inc_q};
    end
    if (cmd_i.step) begin
      wy_q  <= wy_d;
      wm_q  <= wm_d;
      wd_q  <= wd_d;
      cnt_q <= cnt_d;
    end
    if (cmd_i.finish) begin
      if (inv_q) begin
        total_q  <= '0;
        status_q <= dbd_pkg::STATUS_INVALID;
      end else if (cnt_q[dbd_pkg::COUNT_BITS]) begin
        total_q  <= dbd_pkg::COUNT_CAP;
        status_q <= dbd_pkg::STATUS_SAT;
      end else begin
        total_q  <= cnt_q[dbd_pkg::COUNT_BITS-1:0];
        status_q <= dbd_pkg::STATUS_OK;
      end
    end
  end

  assign total_o  = total_q;
  assign status_o = status_q;

endmodule

// ===== src/days_between_dates_top.sv =====
// ----------------------------------------------------------------------------
// days_between_dates_top
// gregorian day count between two dates by a one-day-per-cycle walk
// ----------------------------------------------------------------------------
// usage:
//   slave stream takes one transfer holding start date, end date and the
//   include_end flag; master stream returns one transfer with the day count
//   and a status code (ok, invalid date, saturated).
//   one item at a time: tready on the slave side is high only when idle.
//   after an input transfer the sequencer passes through prep and check;
//   the day stepper then advances one calendar day per cycle until the end
//   date or a count of 32768 is reached, and finish registers the result.
//   an invalid date or a start not before the end skips the walk. slave
//   tready returns in the cycle after the result transfer.
//   the result stays on the master side until it is taken; while the
//   receiver stalls no new transfer is accepted.
//   reset returns the sequencer to idle: master tvalid is low and slave
//   tready is high.
// ----------------------------------------------------------------------------
module days_between_dates_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // start_year, start_month, start_day, end_year, end_month, end_day, pad
  input  logic [dbd_pkg::IN_DATA_BITS-1:0]   s_axis_tdata_i,
  // include_end
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // day_total, pad
  output logic [dbd_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata_o,
  // status
  output logic [dbd_pkg::STATUS_BITS-1:0]    m_axis_tuser_o
);

  dbd_pkg::dbd_cmd_t               cmd;
  dbd_pkg::dbd_sts_t               sts;
  logic [dbd_pkg::COUNT_BITS-1:0]  total;

  dbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dbd_dp u_dp (
    .clk_i     (clk_i),
    .in_data_i (s_axis_tdata_i),
    .in_inc_i  (s_axis_tuser_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .total_o   (total),
    .status_o  (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{(dbd_pkg::OUT_DATA_BITS - dbd_pkg::COUNT_BITS){1'b0}}, total};

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while a result is pending");

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o && !m_axis_tvalid_o)
    else $error("block not busy after accepting a transfer");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == dbd_pkg::STATUS_INVALID)) |->
      (m_axis_tdata_o == '0))
    else $error("invalid date with nonzero count");

  a_sat_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == dbd_pkg::STATUS_SAT)) |->
      (m_axis_tdata_o[dbd_pkg::COUNT_BITS-1:0] == dbd_pkg::COUNT_CAP))
    else $error("saturated status without capped count");

endmodule

// ===== bench/days_between_dates_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// days_between_dates_top_tb
// stream bench for the gregorian day count block
// ----------------------------------------------------------------------------
// date pairs are queued by a stimulus process and offered by a driver at the
// falling edge; a monitor at the rising edge predicts each accepted transfer
// and compares every returned count and status against the oldest
// prediction. phases vary sender gaps and receiver stalls, and one long
// receiver hold-off backs the block up against its input.
// ----------------------------------------------------------------------------
module days_between_dates_top_tb;

  localparam int HOLD_CYCLES = 300;
  // bound on cycles with no transfer; covers the longest walk plus the hold-off, with margin
  localparam int QUIET_LIMIT = 100000;
  localparam int unsigned LATE_YEAR = 16000;
  localparam int unsigned MONTH_LEN [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef enum int {PH_STEADY, PH_SRC_GAPS, PH_SINK_STALLS, PH_BOTH_GAPS} phase_e;

  typedef struct {
    int unsigned yr;
    int unsigned mon;
    int unsigned dy;
  } cal_date_t;

  typedef struct {
    logic [dbd_pkg::YEAR_BITS-1:0]  sy;
    logic [dbd_pkg::MONTH_BITS-1:0] sm;
    logic [dbd_pkg::DAY_BITS-1:0]   sd;
    logic [dbd_pkg::YEAR_BITS-1:0]  ey;
    logic [dbd_pkg::MONTH_BITS-1:0] em;
    logic [dbd_pkg::DAY_BITS-1:0]   ed;
    logic                           incl;
  } date_span_t;

  typedef struct packed {
    logic [dbd_pkg::COUNT_BITS-1:0]  total;
    logic [dbd_pkg::STATUS_BITS-1:0] status;
  } day_count_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              s_axis_tvalid_i = 1'b0;
  logic                              s_axis_tready_o;
  // start_year, start_month, start_day, end_year, end_month, end_day, pad
  logic [dbd_pkg::IN_DATA_BITS-1:0]  s_axis_tdata_i = '0;
  // include_end
  logic                              s_axis_tuser_i = 1'b0;
  logic                              m_axis_tvalid_o;
  logic                              m_axis_tready_i = 1'b0;
  // day_total, pad
  logic [dbd_pkg::OUT_DATA_BITS-1:0] m_axis_tdata_o;
  // status
  logic [dbd_pkg::STATUS_BITS-1:0]   m_axis_tuser_o;

  date_span_t  span_q [$];
  day_count_t  count_q [$];
  int          push_cnt = 0;
  int          done_cnt = 0;
  int          quiet_cycles = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int          hold_left = 0;
  logic        hold_go = 1'b0;
  logic        hold_seen = 1'b0;
  logic        in_took = 1'b0;
  logic        mismatch_seen = 1'b0;

  days_between_dates_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    if (m < 1 || m > 12) return 0;
    if (m == 2) return leap_year(y) ? 29 : 28;
    return MONTH_LEN[m];
  endfunction

  function automatic bit date_ok(int unsigned y, int unsigned m, int unsigned d);
    return (m >= 1) && (m <= 12) && (d >= 1) && (d <= month_days(y, m));
  endfunction

  // running day index, years moved up by one 400-year cycle
  function automatic int unsigned day_number(int unsigned y, int unsigned m, int unsigned d);
    int unsigned ys;
    int unsigned n;
    ys = y + 399;
    n  = ys * 365 + ys / 4 - ys / 100 + ys / 400;
    for (int unsigned k = 1; k < m; k++) n += month_days(y, k);
    return n + d;
  endfunction

  function automatic day_count_t predict_days(logic [dbd_pkg::YEAR_BITS-1:0] sy,
                                              logic [dbd_pkg::MONTH_BITS-1:0] sm,
                                              logic [dbd_pkg::DAY_BITS-1:0] sd,
                                              logic [dbd_pkg::YEAR_BITS-1:0] ey,
                                              logic [dbd_pkg::MONTH_BITS-1:0] em,
                                              logic [dbd_pkg::DAY_BITS-1:0] ed,
                                              logic incl);
    day_count_t  r;
    int unsigned a;
    int unsigned b;
    int unsigned total;
    r.status = dbd_pkg::STATUS_OK;
    total    = 0;
    if (!date_ok(sy, sm, sd) || !date_ok(ey, em, ed)) begin
      r.status = dbd_pkg::STATUS_INVALID;
    end else begin
      a     = day_number(sy, sm, sd);
      b     = day_number(ey, em, ed);
      total = ((a < b) ? (b - a) : 0) + incl;
      if (total > dbd_pkg::COUNT_CAP) begin
        total    = dbd_pkg::COUNT_CAP;
        r.status = dbd_pkg::STATUS_SAT;
      end
    end
    r.total = total[dbd_pkg::COUNT_BITS-1:0];
    return r;
  endfunction

  function automatic cal_date_t date_after(cal_date_t s, int unsigned n);
    cal_date_t c;
    c = s;
    repeat (n) begin
      c.dy++;
      if (c.dy > month_days(c.yr, c.mon)) begin
        c.dy = 1;
        c.mon++;
        if (c.mon > 12) begin
          c.mon = 1;
          c.yr++;
        end
      end
    end
    return c;
  endfunction

  function automatic cal_date_t random_date(int unsigned max_year);
    cal_date_t c;
    c.yr  = $urandom_range(max_year, 0);
    c.mon = $urandom_range(12, 1);
    c.dy  = $urandom_range(month_days(c.yr, c.mon), 1);
    return c;
  endfunction

  task automatic add_span(int unsigned sy, int unsigned sm, int unsigned sd,
                          int unsigned ey, int unsigned em, int unsigned ed, bit incl);
    date_span_t t;
    t.sy   = sy[dbd_pkg::YEAR_BITS-1:0];
    t.sm   = sm[dbd_pkg::MONTH_BITS-1:0];
    t.sd   = sd[dbd_pkg::DAY_BITS-1:0];
    t.ey   = ey[dbd_pkg::YEAR_BITS-1:0];
    t.em   = em[dbd_pkg::MONTH_BITS-1:0];
    t.ed   = ed[dbd_pkg::DAY_BITS-1:0];
    t.incl = incl;
    span_q.push_back(t);
    push_cnt++;
  endtask

  task automatic add_dates(cal_date_t a, cal_date_t b, bit incl);
    add_span(a.yr, a.mon, a.dy, b.yr, b.mon, b.dy, incl);
  endtask

  task automatic queue_random(int n);
    cal_date_t   a;
    cal_date_t   b;
    int unsigned roll;
    int unsigned sy, sm, sd, ey, em, ed;
    repeat (n) begin
      roll = $urandom_range(99, 0);
      if (roll < 15) begin
        // noise: raw fields, at least one date broken
        sy = $urandom_range(16383, 0);
        sm = $urandom_range(15, 0);
        sd = $urandom_range(31, 0);
        ey = $urandom_range(16383, 0);
        em = $urandom_range(15, 0);
        ed = $urandom_range(31, 0);
        if (date_ok(sy, sm, sd) && date_ok(ey, em, ed)) begin
          if ($urandom_range(1, 0)) em = $urandom_range(15, 13);
          else sd = 0;
        end
        add_span(sy, sm, sd, ey, em, ed, $urandom_range(1, 0));
      end else if (roll < 25) begin
        // end on or before start
        b = random_date(LATE_YEAR);
        a = date_after(b, $urandom_range(500, 0));
        add_dates(a, b, $urandom_range(1, 0));
      end else if (roll < 29) begin
        a = random_date(LATE_YEAR);
        add_dates(a, date_after(a, $urandom_range(33000, 32700)), $urandom_range(1, 0));
      end else begin
        a = random_date(LATE_YEAR);
        b = date_after(a, (roll < 45) ? $urandom_range(3000, 0) : $urandom_range(400, 0));
        add_dates(a, b, $urandom_range(1, 0));
      end
    end
  endtask

  // driver
  always @(negedge clk_i) begin : drv
    date_span_t nxt;
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_took) begin
        if (span_q.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
          nxt = span_q.pop_front();
          s_axis_tdata_i  <= {2'b00, nxt.ed, nxt.em, nxt.ey, nxt.sd, nxt.sm, nxt.sy};
          s_axis_tuser_i  <= nxt.incl;
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // receiver with one long hold-off, started while a result is waiting
  always @(negedge clk_i) begin
    if (hold_go && !hold_seen && m_axis_tvalid_o) begin
      hold_seen       <= 1'b1;
      hold_left       <= HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99, 0) >= snk_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin : mon
    day_count_t want;
    in_took <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      count_q.push_back(predict_days(s_axis_tdata_i[13:0], s_axis_tdata_i[17:14],
                                     s_axis_tdata_i[22:18], s_axis_tdata_i[36:23],
                                     s_axis_tdata_i[40:37], s_axis_tdata_i[45:41],
                                     s_axis_tuser_i));
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      done_cnt <= done_cnt + 1;
      if (count_q.size() == 0) begin
        $error("result transfer with no date pair pending");
        mismatch_seen <= 1'b1;
      end else begin
        want = count_q.pop_front();
        if (m_axis_tdata_o[dbd_pkg::COUNT_BITS-1:0] !== want.total) begin
          $error("day_total: expected %0d, got %0d", want.total,
                 m_axis_tdata_o[dbd_pkg::COUNT_BITS-1:0]);
          mismatch_seen <= 1'b1;
        end
        if (m_axis_tuser_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser_o);
          mismatch_seen <= 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stim
    cal_date_t base;
    phase_e    ph;
    add_span(2024, 5, 10, 2024, 5, 10, 1'b0);
    add_span(2024, 5, 10, 2024, 5, 10, 1'b1);
    add_span(2024, 5, 11, 2024, 5, 10, 1'b1);
    add_span(2000, 2, 28, 2000, 3, 1, 1'b0);
    add_span(1900, 2, 28, 1900, 3, 1, 1'b0);
    add_span(2024, 2, 29, 2024, 3, 1, 1'b1);
    add_span(2023, 2, 29, 2023, 3, 1, 1'b0);
    add_span(2023, 1, 1, 2023, 2, 29, 1'b0);
    add_span(2023, 0, 10, 2023, 5, 1, 1'b0);
    add_span(2023, 1, 10, 2023, 13, 1, 1'b1);
    add_span(2023, 15, 31, 2024, 1, 1, 1'b0);
    add_span(2023, 6, 0, 2023, 7, 1, 1'b0);
    add_span(2023, 4, 1, 2023, 4, 31, 1'b0);
    add_span(0, 2, 29, 1, 1, 1, 1'b0);
    add_span(16383, 12, 31, 16383, 12, 31, 1'b1);
    add_span(1999, 12, 31, 2000, 1, 1, 1'b0);
    add_span(16383, 15, 31, 16383, 0, 0, 1'b1);
    add_span(0, 1, 1, 16383, 12, 31, 1'b1);
    base = '{yr: 1, mon: 1, dy: 1};
    add_dates(base, date_after(base, 32767), 1'b0);
    add_dates(base, date_after(base, 32766), 1'b1);
    add_dates(base, date_after(base, 32767), 1'b1);
    add_dates(base, date_after(base, 32768), 1'b0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (done_cnt != push_cnt) @(posedge clk_i);

    for (int pi = 0; pi < 4; pi++) begin
      ph = phase_e'(pi);
      case (ph)
        PH_STEADY: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        PH_SRC_GAPS: begin
          src_idle_pct  = 67;
          snk_stall_pct = 0;
        end
        PH_SINK_STALLS: begin
          src_idle_pct  = 0;
          snk_stall_pct = 67;
        end
        default: begin
          src_idle_pct  = 19;
          snk_stall_pct = 19;
        end
      endcase
      queue_random(20);
      if (ph == PH_STEADY) hold_go = 1'b1;
      while (done_cnt != push_cnt) @(posedge clk_i);
    end

    repeat (40) @(posedge clk_i);
    if (!mismatch_seen && count_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== days_between_dates_top.f =====
src/dbd_pkg.sv
src/dbd_ctrl.sv
src/dbd_dp.sv
src/days_between_dates_top.sv
bench/days_between_dates_top_tb.sv
